[rtl/tql_pkg.sv]
// Shared types, constants and helper functions of the Q-learning agent.
package tql_pkg;

    // Default number of environment states.
    localparam int NUM_STATES_DEF = 9;
    // Actions per state: none, up, down.
    localparam int ACTIONS = 3;

    // Input item modes.
    localparam logic MODE_DECIDE   = 1'b0;
    localparam logic MODE_FEEDBACK = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_LEARN_RATE    = 2'd0;
    localparam logic [1:0] REG_DISCOUNT      = 2'd1;
    localparam logic [1:0] REG_INITIAL_VALUE = 2'd2;
    localparam logic [1:0] REG_START_STATE   = 2'd3;

    // Register values after reset.
    localparam logic [15:0]        RST_LEARN_RATE    = 16'd13107;
    localparam logic [15:0]        RST_DISCOUNT      = 16'd49152;
    localparam logic signed [31:0] RST_INITIAL_VALUE = 32'sd655360;
    localparam logic [3:0]         RST_START_STATE   = 4'd2;

    // Action codes.
    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_UP   = 2'd1,
        ACT_DOWN = 2'd2
    } action_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_EVAL,
        ST_MULG,
        ST_SUM,
        ST_MULA,
        ST_SAT,
        ST_FIN
    } tql_state_t;

    // Payload of one input item.
    typedef struct packed {
        logic               mode;
        logic signed [31:0] performance;
        logic [6:0]         exploit_limit;
        logic [6:0]         explore_draw;
        logic [2:0]         explore_pick;
    } tql_in_t;

    // Payload of one result item.
    typedef struct packed {
        action_t            action;
        logic [3:0]         setting;
        logic signed [31:0] updated_value;
        logic               update_done;
    } tql_out_t;

    // Remainder of the pick roll by the count of allowed actions (1 to 3).
    function automatic logic [1:0] pick_mod(input logic [2:0] pick, input logic [1:0] n);
        logic [1:0] r;
        r = 2'd0;
        unique case (n)
            2'd2: r = {1'b0, pick[0]};
            2'd3:
            begin
                unique case (pick)
                    3'd0, 3'd3, 3'd6: r = 2'd0;
                    3'd1, 3'd4, 3'd7: r = 2'd1;
                    default:          r = 2'd2;
                endcase
            end
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/tql_if.sv]
// Valid/ready channel interfaces for the agent's input and result items.
interface tql_in_if
    import tql_pkg::*;
();
    logic    valid;
    logic    ready;
    tql_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tql_out_if
    import tql_pkg::*;
();
    logic     valid;
    logic     ready;
    tql_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/tql_qtable.sv]
// Action-value memory with per-entry valid bits and a registered read.
module tql_qtable
    import tql_pkg::*;
#(
    parameter int DEPTH = NUM_STATES_DEF * ACTIONS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          flush,
    input  logic signed [31:0]            flush_value,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic signed [31:0]            rd_data,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic signed [31:0]            wr_data
);

    logic signed [31:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic               rd_valid_reg;
    logic signed [31:0] rd_word_reg;
    logic signed [31:0] fill_value_reg;

    // Memory array: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // Valid bits and fill value; a flush makes every entry read as the fill value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            fill_value_reg <= RST_INITIAL_VALUE;
        end
        else
        begin
            if (flush)
            begin
                valid_reg      <= '0;
                fill_value_reg <= flush_value;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Entries never written since the last flush read as the fill value.
    assign rd_data = rd_valid_reg ? rd_word_reg : fill_value_reg;

    // The sequencer never reads and writes in the same cycle.
    a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en))
        else $error("Table read and write in the same cycle.");

    a_rd_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (int'(rd_addr) < DEPTH))
        else $error("Table read address out of range.");

    a_wr_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (int'(wr_addr) < DEPTH))
        else $error("Table write address out of range.");

endmodule

[rtl/tabular_q_learning_agent.sv]
// Top level of the tabular Q-learning agent with epsilon-greedy action choice.
//
//  Channel   Direction  Transfer carries
//  item      in         mode, performance, exploit_limit, explore_draw, explore_pick
//  result    out        action, setting, updated_value, update_done
//  cfg_*     in         register index and write data, one write per enabled edge
//
// One item at a time: a decide passes through the four read steps of the single table
// read port and the evaluation; a feedback with a pending decide also goes through the
// two multiply stages, the sum and the saturation of the update; a feedback with no
// pending decide goes straight to the final step. Reset clears the table through its
// valid bits at once; no clearing pass is needed. A stalled result holds in the output
// register; the sequencer waits in its last step until that register is free.
module tabular_q_learning_agent
    import tql_pkg::*;
#(
    parameter int NUM_STATES = NUM_STATES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tql_in_if.sink      item,
    tql_out_if.source   result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int SW        = $clog2(NUM_STATES);
    localparam int DEPTH     = NUM_STATES * ACTIONS;
    localparam int AW        = $clog2(DEPTH);
    localparam int START_RST = (int'(RST_START_STATE) >= NUM_STATES) ?
                               (NUM_STATES - 1) : int'(RST_START_STATE);

    // Table address of one state and action.
    function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] s, input action_t a);
        return AW'({s, 1'b0}) + AW'(s) + AW'(a);
    endfunction

    // State reached from s by action a.
    function automatic logic [SW-1:0] move_st(input logic [SW-1:0] s, input action_t a);
        logic [SW-1:0] r;
        r = s;
        if (a == ACT_UP && (int'(s) + 1 < NUM_STATES))
        begin
            r = s + 1'b1;
        end
        else if (a == ACT_DOWN && s != '0)
        begin
            r = s - 1'b1;
        end
        return r;
    endfunction

    tql_state_t         state_reg, state_next;

    logic [15:0]        learn_rate_reg;
    logic [15:0]        discount_reg;
    logic signed [31:0] initial_value_reg;
    logic [3:0]         start_state_reg;

    logic [SW-1:0]      cur_st_reg;
    logic [SW-1:0]      tgt_st_reg;
    action_t            pend_act_reg;
    logic               pend_valid_reg;
    logic signed [31:0] last_perf_reg;
    logic [1:0]         fb_cnt_reg;

    tql_in_t            item_reg;
    logic signed [31:0] v0_reg, v1_reg, v2_reg;
    logic signed [31:0] q_reg;
    logic signed [31:0] look_reg;
    action_t            act_reg;
    logic signed [32:0] r_reg;
    logic signed [48:0] gprod_reg;
    logic signed [34:0] diff_reg;
    logic signed [51:0] aprod_reg;
    logic signed [31:0] nq_reg;

    logic               out_valid_reg, out_valid_next;
    tql_out_t           out_data_reg;

    logic               accept;
    logic               is_feedback;
    logic               fb_update;
    logic               fin_load;
    logic [SW-1:0]      start_idx;
    logic [SW-1:0]      look_st;

    logic               tbl_rd_en;
    logic [AW-1:0]      tbl_rd_addr;
    logic signed [31:0] tbl_rd_data;
    logic               tbl_wr_en;
    logic [AW-1:0]      tbl_wr_addr;
    logic               tbl_flush;

    logic               al_up, al_down;
    action_t            best_act;
    logic signed [31:0] best_val;
    action_t            expl_act;
    action_t            dec_act;
    logic [1:0]         n_allowed;
    logic [1:0]         pick_idx;

    logic signed [32:0] r_next;
    logic signed [48:0] gprod_next;
    logic signed [48:0] gsum;
    logic signed [32:0] gterm;
    logic signed [34:0] diff_next;
    logic signed [51:0] aprod_next;
    logic signed [51:0] asum;
    logic signed [35:0] aterm;
    logic signed [36:0] nq_wide;
    logic signed [31:0] nq_next;
    tql_out_t           fin_data;
    logic [SW-1:0]      dec_move;

    assign accept      = item.valid && item.ready;
    assign is_feedback = (item_reg.mode == MODE_FEEDBACK);
    assign fb_update   = is_feedback && pend_valid_reg;
    assign look_st     = is_feedback ? tgt_st_reg : cur_st_reg;
    assign start_idx   = (int'(start_state_reg) >= NUM_STATES) ?
                         SW'(NUM_STATES - 1) : start_state_reg[SW-1:0];

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    if (item.data.mode == MODE_FEEDBACK && !pend_valid_reg)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_RD0;
                    end
                end
            end
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_RD3;
            ST_RD3:  state_next = ST_EVAL;
            ST_EVAL: state_next = is_feedback ? ST_MULG : ST_FIN;
            ST_MULG: state_next = ST_SUM;
            ST_SUM:  state_next = ST_MULA;
            ST_MULA: state_next = ST_SAT;
            ST_SAT:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer: ready, table reads and the final step.
    always_comb
    begin
        item.ready  = 1'b0;
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = addr_of(look_st, ACT_NONE);
        fin_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE: item.ready = 1'b1;
            ST_RD0:  tbl_rd_en  = 1'b1;
            ST_RD1:
            begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = addr_of(look_st, ACT_UP);
            end
            ST_RD2:
            begin
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = addr_of(look_st, ACT_DOWN);
            end
            ST_RD3:
            begin
                tbl_rd_en   = is_feedback;
                tbl_rd_addr = addr_of(cur_st_reg, pend_act_reg);
            end
            ST_FIN:  fin_load = !out_valid_reg || result.ready;
            default: fin_load = 1'b0;
        endcase
    end

    assign tbl_wr_en   = fin_load && fb_update;
    assign tbl_wr_addr = addr_of(cur_st_reg, pend_act_reg);
    assign tbl_flush   = tbl_wr_en && (fb_cnt_reg == 2'd1);

    // Greedy choice and exploration pick over the looked-up state.
    always_comb
    begin
        al_up     = (int'(look_st) + 1 < NUM_STATES);
        al_down   = (look_st != '0);
        best_act  = ACT_NONE;
        best_val  = v0_reg;
        if (al_up && v1_reg > best_val)
        begin
            best_act = ACT_UP;
            best_val = v1_reg;
        end
        if (al_down && v2_reg > best_val)
        begin
            best_act = ACT_DOWN;
            best_val = v2_reg;
        end
        n_allowed = 2'd1 + {1'b0, al_up} + {1'b0, al_down};
        pick_idx  = pick_mod(item_reg.explore_pick, n_allowed);
        unique case (pick_idx)
            2'd0:    expl_act = ACT_NONE;
            2'd1:    expl_act = al_up ? ACT_UP : ACT_DOWN;
            default: expl_act = ACT_DOWN;
        endcase
        dec_act = (item_reg.explore_draw < item_reg.exploit_limit) ? best_act : expl_act;
    end

    // Update arithmetic, one multiply or one wide add per step.
    always_comb
    begin
        r_next     = {item_reg.performance[31], item_reg.performance}
                   - {last_perf_reg[31], last_perf_reg};
        gprod_next = look_reg * $signed({1'b0, discount_reg});
        gsum       = gprod_reg + 49'sd32768;
        gterm      = gsum[48:16];
        diff_next  = {{2{r_reg[32]}}, r_reg} + {{2{gterm[32]}}, gterm}
                   - {{3{q_reg[31]}}, q_reg};
        aprod_next = diff_reg * $signed({1'b0, learn_rate_reg});
        asum       = aprod_reg + 52'sd32768;
        aterm      = asum[51:16];
        nq_wide    = {{5{q_reg[31]}}, q_reg} + {aterm[35], aterm};
        if (nq_wide[36:31] == '0 || nq_wide[36:31] == '1)
        begin
            nq_next = nq_wide[31:0];
        end
        else if (nq_wide[36])
        begin
            nq_next = 32'sh8000_0000;
        end
        else
        begin
            nq_next = 32'sh7FFF_FFFF;
        end
    end

    // Result of the final step.
    always_comb
    begin
        dec_move = move_st(cur_st_reg, act_reg);
        fin_data = '0;
        if (!is_feedback)
        begin
            fin_data.action  = act_reg;
            fin_data.setting = 4'(dec_move);
        end
        else if (pend_valid_reg)
        begin
            fin_data.action        = pend_act_reg;
            fin_data.setting       = 4'(tgt_st_reg);
            fin_data.updated_value = nq_reg;
            fin_data.update_done   = 1'b1;
        end
        else
        begin
            fin_data.action  = ACT_NONE;
            fin_data.setting = 4'(cur_st_reg);
        end
    end

    assign out_valid_next = fin_load ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);
    assign result.valid   = out_valid_reg;
    assign result.data    = out_data_reg;

    // Control state, agent state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            learn_rate_reg    <= RST_LEARN_RATE;
            discount_reg      <= RST_DISCOUNT;
            initial_value_reg <= RST_INITIAL_VALUE;
            start_state_reg   <= RST_START_STATE;
            cur_st_reg        <= SW'(START_RST);
            tgt_st_reg        <= SW'(START_RST);
            pend_act_reg      <= ACT_NONE;
            pend_valid_reg    <= 1'b0;
            last_perf_reg     <= '0;
            fb_cnt_reg        <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LEARN_RATE:    learn_rate_reg    <= cfg_wdata[15:0];
                    REG_DISCOUNT:      discount_reg      <= cfg_wdata[15:0];
                    REG_INITIAL_VALUE: initial_value_reg <= cfg_wdata;
                    REG_START_STATE:   start_state_reg   <= cfg_wdata[3:0];
                    default:           start_state_reg   <= start_state_reg;
                endcase
            end

            if (fin_load && !is_feedback)
            begin
                pend_act_reg   <= act_reg;
                pend_valid_reg <= 1'b1;
                tgt_st_reg     <= dec_move;
            end
            else if (fin_load && fb_update)
            begin
                last_perf_reg  <= item_reg.performance;
                pend_valid_reg <= 1'b0;
                if (fb_cnt_reg != 2'd2)
                begin
                    fb_cnt_reg <= fb_cnt_reg + 2'd1;
                end
                if (tbl_flush)
                begin
                    // Second feedback: restart from the start state.
                    cur_st_reg   <= start_idx;
                    tgt_st_reg   <= start_idx;
                    pend_act_reg <= ACT_NONE;
                end
                else
                begin
                    cur_st_reg <= tgt_st_reg;
                end
            end
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item.data;
        end
        if (state_reg == ST_RD1)
        begin
            v0_reg <= tbl_rd_data;
        end
        if (state_reg == ST_RD2)
        begin
            v1_reg <= tbl_rd_data;
        end
        if (state_reg == ST_RD3)
        begin
            v2_reg <= tbl_rd_data;
        end
        if (state_reg == ST_EVAL)
        begin
            q_reg    <= tbl_rd_data;
            look_reg <= best_val;
            act_reg  <= dec_act;
            r_reg    <= r_next;
        end
        if (state_reg == ST_MULG)
        begin
            gprod_reg <= gprod_next;
        end
        if (state_reg == ST_SUM)
        begin
            diff_reg <= diff_next;
        end
        if (state_reg == ST_MULA)
        begin
            aprod_reg <= aprod_next;
        end
        if (state_reg == ST_SAT)
        begin
            nq_reg <= nq_next;
        end
        if (fin_load)
        begin
            out_data_reg <= fin_data;
        end
    end

    tql_qtable #(
        .DEPTH (DEPTH)
    ) u_qtable (
        .clk         (clk),
        .rst_n       (rst_n),
        .flush       (tbl_flush),
        .flush_value (initial_value_reg),
        .rd_en       (tbl_rd_en),
        .rd_addr     (tbl_rd_addr),
        .rd_data     (tbl_rd_data),
        .wr_en       (tbl_wr_en),
        .wr_addr     (tbl_wr_addr),
        .wr_data     (nq_reg)
    );

    // The reinitialization happens once, so the feedback count stops at two.
    a_fb_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
        fb_cnt_reg != 2'd3)
        else $error("Feedback count passed two.");

    // Both state registers stay inside the state space.
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(cur_st_reg) < NUM_STATES) && (int'(tgt_st_reg) < NUM_STATES))
        else $error("Agent state out of range.");

    // A table write only comes from a feedback that had a pending decide.
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr_en |-> (state_reg == ST_FIN && is_feedback && pend_valid_reg))
        else $error("Table write without a pending decide.");

    // A table update comes with a result flagged as an update.
    a_update_action: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr_en |=> (out_valid_reg && out_data_reg.update_done))
        else $error("Table update without an update result.");

endmodule

[bench/tql_agent_checker.sv]
// Checker for the Q-learning agent: predicts each result from the item transfers and compares.
module tql_agent_checker
    import tql_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  tql_in_t     item_data,
    input  logic        res_valid,
    input  logic        res_ready,
    input  tql_out_t    res_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NS = NUM_STATES_DEF;
    localparam int NQ = NS * ACTIONS;

    // Register copies.
    logic [15:0]        alpha_r;
    logic [15:0]        gamma_r;
    logic signed [31:0] fill_r;
    logic [3:0]         start_r;

    // Agent state as the block should hold it.
    logic signed [31:0] qtab [NQ];
    logic [3:0]         cur_s;
    logic [3:0]         nxt_s;
    action_t            pend_act;
    logic               pend_ok;
    logic signed [63:0] last_perf;
    logic [1:0]         fb_count;

    tql_out_t expected_results [$];
    tql_out_t want;
    tql_out_t got;
    tql_out_t prediction;

    function automatic bit act_allowed(int s, int a);
        if (a == int'(ACT_UP))
            return s + 1 < NS;
        if (a == int'(ACT_DOWN))
            return s > 0;
        return 1'b1;
    endfunction

    function automatic int move_to(int s, int a);
        if (a == int'(ACT_UP) && s + 1 < NS)
            return s + 1;
        if (a == int'(ACT_DOWN) && s > 0)
            return s - 1;
        return s;
    endfunction

    // Best allowed action; a tie keeps the lower action.
    function automatic int greedy_choice(int s);
        int best;
        best = int'(ACT_NONE);
        for (int a = 1; a < ACTIONS; a++)
        begin
            if (act_allowed(s, a) && qtab[s * ACTIONS + a] > qtab[s * ACTIONS + best])
                best = a;
        end
        return best;
    endfunction

    // Q16.16 value times Q0.16 fraction, rounded to nearest with ties upward.
    function automatic logic signed [63:0] frac_scale(logic signed [63:0] x, logic [15:0] f);
        logic signed [63:0] p;
        p = x * $signed({48'd0, f}) + 64'sd32768;
        return p >>> 16;
    endfunction

    // Fill the table and return to the start state.
    task automatic refill_table();
        for (int i = 0; i < NQ; i++)
            qtab[i] = fill_r;
        cur_s = (start_r >= NS) ? 4'(NS - 1) : start_r;
        nxt_s = cur_s;
        pend_act = ACT_NONE;
        pend_ok = 1'b0;
    endtask

    // Work out the result of one item and advance the agent state.
    task automatic predict_agent_step(input tql_in_t it, output tql_out_t res);
        int                 s_now;
        int                 s_next;
        int                 act;
        int                 n;
        int                 list [ACTIONS];
        int                 idx;
        logic signed [63:0] perf;
        logic signed [63:0] reward;
        logic signed [63:0] look;
        logic signed [63:0] q;
        logic signed [63:0] sample;
        logic signed [63:0] nq;

        s_now = cur_s;
        res.action = ACT_NONE;
        res.setting = cur_s;
        res.updated_value = '0;
        res.update_done = 1'b0;

        if (it.mode == MODE_DECIDE)
        begin
            if (it.explore_draw < it.exploit_limit)
                act = greedy_choice(s_now);
            else
            begin
                n = 0;
                for (int a = 0; a < ACTIONS; a++)
                begin
                    if (act_allowed(s_now, a))
                    begin
                        list[n] = a;
                        n++;
                    end
                end
                act = list[int'(it.explore_pick) % n];
            end
            pend_act = action_t'(act);
            pend_ok = 1'b1;
            nxt_s = 4'(move_to(s_now, act));
            res.action = action_t'(act);
            res.setting = nxt_s;
        end
        else if (pend_ok)
        begin
            // Temporal-difference update of the entry of the pending decision.
            s_next = nxt_s;
            idx = s_now * ACTIONS + int'(pend_act);
            perf = it.performance;
            reward = perf - last_perf;
            look = qtab[s_next * ACTIONS + greedy_choice(s_next)];
            q = qtab[idx];
            sample = reward + frac_scale(look, gamma_r);
            nq = q + frac_scale(sample - q, alpha_r);
            if (nq > 64'sd2147483647)
                nq = 64'sd2147483647;
            else if (nq < -64'sd2147483648)
                nq = -64'sd2147483648;
            qtab[idx] = nq[31:0];
            last_perf = perf;
            cur_s = nxt_s;
            pend_ok = 1'b0;

            res.action = pend_act;
            res.setting = nxt_s;
            res.updated_value = nq[31:0];
            res.update_done = 1'b1;

            // The second update after reset starts the table over, once only.
            if (fb_count < 2)
            begin
                fb_count++;
                if (fb_count == 2)
                    refill_table();
            end
        end
    endtask

    // Compare result transfers, predict item transfers and track register writes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_r = RST_LEARN_RATE;
            gamma_r = RST_DISCOUNT;
            fill_r = RST_INITIAL_VALUE;
            start_r = RST_START_STATE;
            last_perf = '0;
            fb_count = '0;
            refill_table();
            expected_results.delete();
            waiting = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                got = res_data;
                if (expected_results.size() == 0)
                begin
                    $error("result transfer with no result expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.action !== want.action)
                    begin
                        $error("action: expected %0d, actual %0d", want.action, got.action);
                        fail_count++;
                    end
                    if (got.setting !== want.setting)
                    begin
                        $error("setting: expected %0d, actual %0d", want.setting, got.setting);
                        fail_count++;
                    end
                    if (got.updated_value !== want.updated_value)
                    begin
                        $error("updated_value: expected %0d, actual %0d",
                               want.updated_value, got.updated_value);
                        fail_count++;
                    end
                    if (got.update_done !== want.update_done)
                    begin
                        $error("update_done: expected %0d, actual %0d",
                               want.update_done, got.update_done);
                        fail_count++;
                    end
                end
            end

            if (item_valid && item_ready)
            begin
                predict_agent_step(item_data, prediction);
                expected_results.push_back(prediction);
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LEARN_RATE:    alpha_r = cfg_wdata[15:0];
                    REG_DISCOUNT:      gamma_r = cfg_wdata[15:0];
                    REG_INITIAL_VALUE: fill_r = cfg_wdata;
                    REG_START_STATE:   start_r = cfg_wdata[3:0];
                    default:           ;
                endcase
            end

            waiting = expected_results.size();
        end
    end

endmodule

[bench/tabular_q_learning_agent_tb.sv]
// Testbench top for the Q-learning agent: clock, reset, stimulus, receiver and verdict.
module tabular_q_learning_agent_tb
    import tql_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    int fail_count;
    int waiting;

    // Flags of the stimulus; quiet and hold_request also steer the receiver.
    bit quiet = 1'b0;
    bit hold_request = 1'b0;
    bit decide_open = 1'b0;

    tql_in_if  item_ch ();
    tql_out_if result_ch ();

    tabular_q_learning_agent uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    tql_agent_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_ch.valid),
        .item_ready (item_ch.ready),
        .item_data  (item_ch.data),
        .res_valid  (result_ch.valid),
        .res_ready  (result_ch.ready),
        .res_data   (result_ch.data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .waiting    (waiting)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit.
    initial
    begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stalls, a long hold-off on request, none while quiet.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            result_ch.ready <= quiet || ($urandom_range(99) >= 12);
        end
    end

    function automatic logic signed [31:0] rand_perf();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15)
            return $urandom;
        if (sel < 18)
            return 32'sh7FFF_FFFF;
        if (sel < 21)
            return 32'sh8000_0000;
        return int'($urandom_range(2097152)) - 1048576;
    endfunction

    function automatic tql_in_t decide_item(int lim, int drw, int pk);
        tql_in_t it;
        it.mode = MODE_DECIDE;
        it.performance = $urandom;
        it.exploit_limit = 7'(lim);
        it.explore_draw = 7'(drw);
        it.explore_pick = 3'(pk);
        return it;
    endfunction

    function automatic tql_in_t feedback_item(logic signed [31:0] perf);
        tql_in_t it;
        it.mode = MODE_FEEDBACK;
        it.performance = perf;
        it.exploit_limit = 7'($urandom_range(100));
        it.explore_draw = 7'($urandom_range(100));
        it.explore_pick = 3'($urandom_range(5));
        return it;
    endfunction

    function automatic tql_in_t rand_decide();
        return decide_item($urandom_range(100), $urandom_range(100), $urandom_range(5));
    endfunction

    // Offer one item, with random gaps unless quiet, and wait for its transfer.
    task automatic offer_item(input tql_in_t it);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 12)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        decide_open = (it.mode == MODE_DECIDE);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait for every expected result, then let the sequencer return to idle.
    task automatic settle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    // Mostly decide/feedback pairs; the rest are replaced decides and lone feedbacks.
    task automatic run_random(input int target);
        int  done_cnt;
        int  sel;
        bit  was_open;
        done_cnt = 0;
        while (done_cnt < target)
        begin
            sel = $urandom_range(99);
            if (sel < 80)
            begin
                offer_item(rand_decide());
                offer_item(feedback_item(rand_perf()));
                done_cnt += 2;
            end
            else if (sel < 90)
            begin
                offer_item(rand_decide());
                done_cnt++;
            end
            else
            begin
                was_open = decide_open;
                offer_item(feedback_item(rand_perf()));
                if (was_open)
                    done_cnt++;
            end
        end
    endtask

    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_LEARN_RATE;
        cfg_wdata = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Extreme registers; start state out of range maps to the top state.
        write_reg(REG_LEARN_RATE, 32'h0000_FFFF);
        write_reg(REG_DISCOUNT, 32'h0000_FFFF);
        write_reg(REG_INITIAL_VALUE, 32'h8000_0000);
        write_reg(REG_START_STATE, 32'd15);

        // Directed part: ignored feedback, replaced decide, refill, saturation, ties.
        offer_item(feedback_item(32'sd123));
        offer_item(decide_item(100, 0, 0));
        offer_item(decide_item(0, 0, 5));
        offer_item(feedback_item(32'sh7FFF_FFFF));
        offer_item(decide_item(50, 100, 4));
        offer_item(feedback_item(32'sh8000_0000));
        offer_item(decide_item(100, 99, 0));
        offer_item(decide_item(0, 100, 3));
        offer_item(feedback_item(32'sh7FFF_FFFF));
        offer_item(decide_item(37, 37, 0));
        offer_item(feedback_item(32'sh8000_0000));
        offer_item(decide_item(0, 0, 1));
        offer_item(feedback_item(32'sd0));
        offer_item(decide_item(100, 0, 0));
        offer_item(feedback_item(-32'sd5));
        offer_item(decide_item(1, 0, 2));
        offer_item(decide_item(20, 80, 2));
        offer_item(feedback_item(32'sd65536));
        offer_item(decide_item(100, 100, 5));
        offer_item(feedback_item(32'sh0000_FFFF));
        offer_item(feedback_item(32'sh1234_5678));
        settle();

        // Reset-like settings, with a long receiver hold-off while items keep coming.
        write_reg(REG_LEARN_RATE, 32'(RST_LEARN_RATE));
        write_reg(REG_DISCOUNT, 32'(RST_DISCOUNT));
        write_reg(REG_INITIAL_VALUE, RST_INITIAL_VALUE);
        write_reg(REG_START_STATE, 32'(RST_START_STATE));
        hold_request = 1'b1;
        run_random(200);
        settle();

        // Zero alpha and gamma, with no idling on either side.
        write_reg(REG_LEARN_RATE, 32'd0);
        write_reg(REG_DISCOUNT, 32'd0);
        write_reg(REG_START_STATE, 32'd0);
        quiet = 1'b1;
        run_random(150);
        settle();
        quiet = 1'b0;

        // Full-scale alpha and gamma.
        write_reg(REG_LEARN_RATE, 32'h0000_FFFF);
        write_reg(REG_DISCOUNT, 32'h0000_FFFF);
        write_reg(REG_INITIAL_VALUE, 32'h7FFF_FFFF);
        write_reg(REG_START_STATE, 32'd8);
        run_random(150);
        settle();

        // Random settings.
        write_reg(REG_LEARN_RATE, 32'($urandom_range(65535)));
        write_reg(REG_DISCOUNT, 32'($urandom_range(65535)));
        write_reg(REG_INITIAL_VALUE, $urandom);
        write_reg(REG_START_STATE, 32'($urandom_range(8)));
        run_random(100);
        settle();

        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
